/* hw/rtl/mau_pkg.sv */
// ----------------------------------------------------------------------------
// mau_pkg
// shared types and constants of the modular arithmetic unit
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int MOD_BITS_DEF = 31;
  localparam int EXP_BITS_DEF = 32;
  localparam int MOD_RESET    = 998244353;
  localparam int NQR_LIMIT    = 4096;
  localparam int NQR_BITS     = 13;
  localparam int OPND_BITS    = 32;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NEG  = 3'd4,
    OP_POW  = 3'd5,
    OP_SQRT = 3'd6,
    OP_EQ   = 3'd7
  } opcode_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WT,
    ST_RA,
    ST_RB,
    ST_DISPATCH,
    ST_MUL_GO,
    ST_MUL_WT,
    ST_POW_LOOP,
    ST_POW_R1,
    ST_POW_R2,
    ST_FIN_MUL,
    ST_FIN_POW,
    ST_EU_LOOP,
    ST_EU_WT,
    ST_DIV_RED,
    ST_SQ_START,
    ST_SQ3_P,
    ST_SQ3_C,
    ST_SQ_STRIP,
    ST_NQR,
    ST_NQR_C,
    ST_TS_C0,
    ST_TS_T0,
    ST_TS_R0,
    ST_TS_LOOP,
    ST_TS_SQ,
    ST_TS_SQR,
    ST_TS_B,
    ST_TS_BR,
    ST_TS_C2,
    ST_TS_T2,
    ST_TS_R2,
    ST_ROOT2
  } state_e;

endpackage

/* hw/rtl/modular_arithmetic_unit_core.sv */
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_core
// modular alu: add, sub, mul, div, neg, pow, sqrt and compare over a modulus
// ----------------------------------------------------------------------------
//
//  channel   signals                                  handshake
//  --------  ---------------------------------------  ---------------------------
//  command   opcode_i lhs_i rhs_i exponent_i          start_i high, busy_o low
//  result    value_o is_equal_o no_root_o last_o      result_valid_o, one cycle
//  config    cfg_wdata_i                              cfg_we_i, no wait
//
//  every operation runs on one shared restoring divider (one bit a cycle) fed
//  by one multiplier; a modular multiply is one product and a full-width
//  reduction, and every operand is reduced first; pow takes about
//  2*EXP_BITS multiplies, and sqrt a few pow runs plus the non-residue search
//  busy_o stays high from the accepted word and drops in the cycle that its
//  final result word is strobed
//  reset clears the sequencer and loads the default modulus
//  results cannot be held off by the receiver; each is strobed once
//
module modular_arithmetic_unit_core #(
  parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF,
  parameter int EXP_BITS = mau_pkg::EXP_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MOD_BITS-1:0] cfg_wdata_i,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [2:0]          opcode_i,
  input  logic signed [31:0]  lhs_i,
  input  logic signed [31:0]  rhs_i,
  input  logic [31:0]         exponent_i,
  output logic                result_valid_o,
  output logic [MOD_BITS-1:0] value_o,
  output logic                is_equal_o,
  output logic                no_root_o,
  output logic                last_o
);

  localparam int MB = MOD_BITS;
  localparam int DW = (2 * MB > mau_pkg::OPND_BITS) ? 2 * MB : mau_pkg::OPND_BITS;
  localparam int NW = $clog2(DW + 1);
  localparam int PW = (EXP_BITS > MB) ? EXP_BITS : MB;
  localparam int XW = MB + 1;
  localparam int SW = $clog2(MB + 1);
  localparam int LW = (MB > mau_pkg::NQR_BITS) ? MB : mau_pkg::NQR_BITS;
  localparam int ZW = mau_pkg::NQR_BITS;

  // sequencer state and subroutine return points
  mau_pkg::state_e  state_q, state_d;
  mau_pkg::state_e  mul_ret_q, mul_ret_d;
  mau_pkg::state_e  pow_ret_q, pow_ret_d;
  mau_pkg::state_e  red_ret_q, red_ret_d;
  mau_pkg::opcode_e op_q, op_d;

  logic [MB-1:0] modulus_q;
  logic [MB-1:0] m_eff;
  logic [MB-1:0] m_q, m_d;
  logic [EXP_BITS-1:0] e_q, e_d;
  logic signed [31:0] rhs_q, rhs_d;
  logic signed [31:0] red_in_q, red_in_d;
  logic [MB-1:0] red_res_q, red_res_d;
  logic [MB-1:0] a_q, a_d, b_q, b_d;
  logic [MB-1:0] mul_x_q, mul_x_d, mul_y_q, mul_y_d, mul_res_q, mul_res_d;
  logic [MB-1:0] pw_base_q, pw_base_d, pw_res_q, pw_res_d;
  logic [PW-1:0] pw_exp_q, pw_exp_d;
  logic [MB-1:0] eu_a_q, eu_a_d, eu_b_q, eu_b_d;
  logic signed [XW-1:0] eu_x_q, eu_x_d, eu_u_q, eu_u_d;
  logic [MB-1:0] sq_q, sq_d;
  logic [SW-1:0] s_q, s_d, i_q, i_d, j_q, j_d, mm_q, mm_d;
  logic [LW-1:0] lim_q, lim_d;
  logic [ZW-1:0] z0_q, z0_d;
  logic [MB-1:0] z_q, z_d, c_q, c_d, t_q, t_d, r_q, r_d, tt_q, tt_d, tb_q, tb_d;

  // result word registers
  logic          rv_q, rv_d;
  logic [MB-1:0] val_q, val_d;
  logic          eq_q, eq_d, nr_q, nr_d, last_q, last_d;

  // shared divider
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [MB-1:0] div_divisor;
  logic [NW-1:0] div_nbits;
  logic          div_done;
  logic [DW-1:0] div_quot;
  logic [MB-1:0] div_rem;

  logic [2*MB-1:0]        mul_prod;
  logic [31:0]            red_mag;
  logic signed [2*XW-1:0] eu_prod;
  logic [MB-1:0]          one_m;
  logic [MB:0]            sum_w, sub_w, mp1;
  logic [SW:0]            jsum;
  logic [MB-1:0]          neg_a, neg_r;

  mau_div #(
    .MOD_BITS(MB)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .nbits_i   (div_nbits),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // a modulus below two behaves as one
  assign m_eff    = (modulus_q < MB'(2)) ? MB'(1) : modulus_q;
  assign mul_prod = mul_x_q * mul_y_q;
  assign red_mag  = red_in_q[31] ? 32'(-red_in_q) : red_in_q;
  assign eu_prod  = $signed({1'b0, div_quot[MB-1:0]}) * eu_u_q;
  assign one_m    = (m_q == MB'(1)) ? '0 : MB'(1);
  assign sum_w    = {1'b0, a_q} + {1'b0, b_q};
  assign sub_w    = {1'b0, a_q} + {1'b0, m_q} - {1'b0, b_q};
  assign mp1      = {1'b0, m_q} + 1'b1;
  assign jsum     = (SW + 1)'(j_q) + (SW + 1)'(i_q) + 1'b1;
  assign neg_a    = (a_q == '0) ? '0 : m_q - a_q;
  assign neg_r    = (r_q == '0) ? '0 : m_q - r_q;

  always_comb begin
    state_d   = state_q;
    mul_ret_d = mul_ret_q;
    pow_ret_d = pow_ret_q;
    red_ret_d = red_ret_q;
    op_d      = op_q;
    m_d       = m_q;
    e_d       = e_q;
    rhs_d     = rhs_q;
    red_in_d  = red_in_q;
    red_res_d = red_res_q;
    a_d       = a_q;
    b_d       = b_q;
    mul_x_d   = mul_x_q;
    mul_y_d   = mul_y_q;
    mul_res_d = mul_res_q;
    pw_base_d = pw_base_q;
    pw_exp_d  = pw_exp_q;
    pw_res_d  = pw_res_q;
    eu_a_d    = eu_a_q;
    eu_b_d    = eu_b_q;
    eu_x_d    = eu_x_q;
    eu_u_d    = eu_u_q;
    sq_d      = sq_q;
    s_d       = s_q;
    i_d       = i_q;
    j_d       = j_q;
    mm_d      = mm_q;
    lim_d     = lim_q;
    z0_d      = z0_q;
    z_d       = z_q;
    c_d       = c_q;
    t_d       = t_q;
    r_d       = r_q;
    tt_d      = tt_q;
    tb_d      = tb_q;
    rv_d      = 1'b0;
    val_d     = val_q;
    eq_d      = eq_q;
    nr_d      = nr_q;
    last_d    = last_q;

    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = m_q;
    div_nbits    = '0;

    case (state_q)
      mau_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d      = mau_pkg::opcode_e'(opcode_i);
          m_d       = m_eff;
          e_d       = EXP_BITS'(exponent_i);
          rhs_d     = rhs_i;
          red_in_d  = lhs_i;
          red_ret_d = mau_pkg::ST_RA;
          state_d   = mau_pkg::ST_RED_GO;
        end
      end

      // operand reduction, truncating remainder folded into range
      mau_pkg::ST_RED_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(red_mag);
        div_nbits    = NW'(32);
        state_d      = mau_pkg::ST_RED_WT;
      end
      mau_pkg::ST_RED_WT: begin
        if (div_done) begin
          red_res_d = (red_in_q[31] && div_rem != '0) ? m_q - div_rem : div_rem;
          state_d   = red_ret_q;
        end
      end
      mau_pkg::ST_RA: begin
        a_d       = red_res_q;
        red_in_d  = rhs_q;
        red_ret_d = mau_pkg::ST_RB;
        state_d   = mau_pkg::ST_RED_GO;
      end
      mau_pkg::ST_RB: begin
        b_d     = red_res_q;
        state_d = mau_pkg::ST_DISPATCH;
      end

      mau_pkg::ST_DISPATCH: begin
        case (op_q)
          mau_pkg::OP_ADD: begin
            rv_d    = 1'b1;
            val_d   = (sum_w >= {1'b0, m_q}) ? MB'(sum_w - {1'b0, m_q}) : MB'(sum_w);
            eq_d    = 1'b0;
            nr_d    = 1'b0;
            last_d  = 1'b1;
            state_d = mau_pkg::ST_IDLE;
          end
          mau_pkg::OP_SUB: begin
            rv_d    = 1'b1;
            val_d   = (a_q >= b_q) ? a_q - b_q : MB'(sub_w);
            eq_d    = 1'b0;
            nr_d    = 1'b0;
            last_d  = 1'b1;
            state_d = mau_pkg::ST_IDLE;
          end
          mau_pkg::OP_MUL: begin
            mul_x_d   = a_q;
            mul_y_d   = b_q;
            mul_ret_d = mau_pkg::ST_FIN_MUL;
            state_d   = mau_pkg::ST_MUL_GO;
          end
          mau_pkg::OP_DIV: begin
            eu_a_d  = b_q;
            eu_b_d  = m_q;
            eu_x_d  = '0;
            eu_u_d  = XW'(1);
            state_d = mau_pkg::ST_EU_LOOP;
          end
          mau_pkg::OP_NEG: begin
            rv_d    = 1'b1;
            val_d   = neg_a;
            eq_d    = 1'b0;
            nr_d    = 1'b0;
            last_d  = 1'b1;
            state_d = mau_pkg::ST_IDLE;
          end
          mau_pkg::OP_POW: begin
            pw_base_d = a_q;
            pw_exp_d  = PW'(e_q);
            pw_res_d  = one_m;
            pow_ret_d = mau_pkg::ST_FIN_POW;
            state_d   = mau_pkg::ST_POW_LOOP;
          end
          mau_pkg::OP_SQRT: begin
            state_d = mau_pkg::ST_SQ_START;
          end
          mau_pkg::OP_EQ: begin
            rv_d    = 1'b1;
            val_d   = '0;
            eq_d    = (a_q == b_q);
            nr_d    = 1'b0;
            last_d  = 1'b1;
            state_d = mau_pkg::ST_IDLE;
          end
          default: begin
            state_d = mau_pkg::ST_IDLE;
          end
        endcase
      end

      // modular multiply: one product, then a full-width reduction
      mau_pkg::ST_MUL_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(mul_prod);
        div_nbits    = NW'(2 * MB);
        state_d      = mau_pkg::ST_MUL_WT;
      end
      mau_pkg::ST_MUL_WT: begin
        if (div_done) begin
          mul_res_d = div_rem;
          state_d   = mul_ret_q;
        end
      end

      // square and multiply, low exponent bit first
      mau_pkg::ST_POW_LOOP: begin
        if (pw_exp_q == '0) begin
          state_d = pow_ret_q;
        end else if (pw_exp_q[0]) begin
          mul_x_d   = pw_res_q;
          mul_y_d   = pw_base_q;
          mul_ret_d = mau_pkg::ST_POW_R1;
          state_d   = mau_pkg::ST_MUL_GO;
        end else begin
          mul_x_d   = pw_base_q;
          mul_y_d   = pw_base_q;
          mul_ret_d = mau_pkg::ST_POW_R2;
          state_d   = mau_pkg::ST_MUL_GO;
        end
      end
      mau_pkg::ST_POW_R1: begin
        pw_res_d  = mul_res_q;
        mul_x_d   = pw_base_q;
        mul_y_d   = pw_base_q;
        mul_ret_d = mau_pkg::ST_POW_R2;
        state_d   = mau_pkg::ST_MUL_GO;
      end
      mau_pkg::ST_POW_R2: begin
        pw_base_d = mul_res_q;
        pw_exp_d  = pw_exp_q >> 1;
        state_d   = mau_pkg::ST_POW_LOOP;
      end

      mau_pkg::ST_FIN_MUL: begin
        rv_d    = 1'b1;
        val_d   = mul_res_q;
        eq_d    = 1'b0;
        nr_d    = 1'b0;
        last_d  = 1'b1;
        state_d = mau_pkg::ST_IDLE;
      end
      mau_pkg::ST_FIN_POW: begin
        rv_d    = 1'b1;
        val_d   = pw_res_q;
        eq_d    = 1'b0;
        nr_d    = 1'b0;
        last_d  = 1'b1;
        state_d = mau_pkg::ST_IDLE;
      end

      // extended euclid, only the coefficient of the divisor is kept
      mau_pkg::ST_EU_LOOP: begin
        if (eu_a_q == '0) begin
          red_in_d  = 32'(eu_x_q);
          red_ret_d = mau_pkg::ST_DIV_RED;
          state_d   = mau_pkg::ST_RED_GO;
        end else begin
          div_start    = 1'b1;
          div_dividend = DW'(eu_b_q);
          div_divisor  = eu_a_q;
          div_nbits    = NW'(MB);
          state_d      = mau_pkg::ST_EU_WT;
        end
      end
      mau_pkg::ST_EU_WT: begin
        if (div_done) begin
          eu_x_d  = eu_u_q;
          eu_u_d  = XW'(eu_x_q - eu_prod);
          eu_b_d  = eu_a_q;
          eu_a_d  = div_rem;
          state_d = mau_pkg::ST_EU_LOOP;
        end
      end
      mau_pkg::ST_DIV_RED: begin
        mul_x_d   = a_q;
        mul_y_d   = red_res_q;
        mul_ret_d = mau_pkg::ST_FIN_MUL;
        state_d   = mau_pkg::ST_MUL_GO;
      end

      // square root
      mau_pkg::ST_SQ_START: begin
        if (a_q == '0) begin
          rv_d    = 1'b1;
          val_d   = '0;
          eq_d    = 1'b0;
          nr_d    = 1'b0;
          last_d  = 1'b1;
          state_d = mau_pkg::ST_IDLE;
        end else if (m_q[1:0] == 2'b11) begin
          pw_base_d = a_q;
          pw_exp_d  = PW'(mp1 >> 2);
          pw_res_d  = one_m;
          pow_ret_d = mau_pkg::ST_SQ3_P;
          state_d   = mau_pkg::ST_POW_LOOP;
        end else begin
          sq_d    = m_q - 1'b1;
          s_d     = '0;
          lim_d   = (LW'(m_q - 1'b1) < LW'(mau_pkg::NQR_LIMIT))
                    ? LW'(m_q - 1'b1) : LW'(mau_pkg::NQR_LIMIT);
          state_d = mau_pkg::ST_SQ_STRIP;
        end
      end
      mau_pkg::ST_SQ3_P: begin
        r_d       = pw_res_q;
        mul_x_d   = pw_res_q;
        mul_y_d   = pw_res_q;
        mul_ret_d = mau_pkg::ST_SQ3_C;
        state_d   = mau_pkg::ST_MUL_GO;
      end
      mau_pkg::ST_SQ3_C: begin
        rv_d   = 1'b1;
        eq_d   = 1'b0;
        if (mul_res_q == a_q) begin
          val_d   = r_q;
          nr_d    = 1'b0;
          last_d  = 1'b0;
          state_d = mau_pkg::ST_ROOT2;
        end else begin
          val_d   = '0;
          nr_d    = 1'b1;
          last_d  = 1'b1;
          state_d = mau_pkg::ST_IDLE;
        end
      end
      mau_pkg::ST_SQ_STRIP: begin
        if (!sq_q[0]) begin
          sq_d = sq_q >> 1;
          s_d  = s_q + 1'b1;
        end else begin
          z0_d    = ZW'(2);
          z_d     = '0;
          state_d = mau_pkg::ST_NQR;
        end
      end

      // non-residue search over small candidates
      mau_pkg::ST_NQR: begin
        if (LW'(z0_q) > lim_q) begin
          if (lim_q < LW'(m_q - 1'b1)) begin
            rv_d    = 1'b1;
            val_d   = '0;
            eq_d    = 1'b0;
            nr_d    = 1'b1;
            last_d  = 1'b1;
            state_d = mau_pkg::ST_IDLE;
          end else begin
            mm_d      = s_q;
            pw_base_d = z_q;
            pw_exp_d  = PW'(sq_q);
            pw_res_d  = one_m;
            pow_ret_d = mau_pkg::ST_TS_C0;
            state_d   = mau_pkg::ST_POW_LOOP;
          end
        end else begin
          z_d       = MB'(z0_q);
          pw_base_d = MB'(z0_q);
          pw_exp_d  = PW'((m_q - 1'b1) >> 1);
          pw_res_d  = one_m;
          pow_ret_d = mau_pkg::ST_NQR_C;
          state_d   = mau_pkg::ST_POW_LOOP;
        end
      end
      mau_pkg::ST_NQR_C: begin
        if (pw_res_q == m_q - 1'b1) begin
          mm_d      = s_q;
          pw_base_d = z_q;
          pw_exp_d  = PW'(sq_q);
          pw_res_d  = one_m;
          pow_ret_d = mau_pkg::ST_TS_C0;
          state_d   = mau_pkg::ST_POW_LOOP;
        end else begin
          z0_d    = z0_q + 1'b1;
          state_d = mau_pkg::ST_NQR;
        end
      end

      // tonelli-shanks set-up
      mau_pkg::ST_TS_C0: begin
        c_d       = pw_res_q;
        pw_base_d = a_q;
        pw_exp_d  = PW'(sq_q);
        pw_res_d  = one_m;
        pow_ret_d = mau_pkg::ST_TS_T0;
        state_d   = mau_pkg::ST_POW_LOOP;
      end
      mau_pkg::ST_TS_T0: begin
        t_d       = pw_res_q;
        pw_base_d = a_q;
        pw_exp_d  = PW'(({1'b0, sq_q} + 1'b1) >> 1);
        pw_res_d  = one_m;
        pow_ret_d = mau_pkg::ST_TS_R0;
        state_d   = mau_pkg::ST_POW_LOOP;
      end
      mau_pkg::ST_TS_R0: begin
        r_d     = pw_res_q;
        state_d = mau_pkg::ST_TS_LOOP;
      end

      mau_pkg::ST_TS_LOOP: begin
        if (t_q == '0) begin
          rv_d    = 1'b1;
          val_d   = '0;
          eq_d    = 1'b0;
          nr_d    = 1'b0;
          last_d  = 1'b1;
          state_d = mau_pkg::ST_IDLE;
        end else if (t_q == MB'(1)) begin
          rv_d    = 1'b1;
          val_d   = r_q;
          eq_d    = 1'b0;
          nr_d    = 1'b0;
          last_d  = 1'b0;
          state_d = mau_pkg::ST_ROOT2;
        end else begin
          tt_d    = t_q;
          i_d     = '0;
          state_d = mau_pkg::ST_TS_SQ;
        end
      end
      mau_pkg::ST_TS_SQ: begin
        if (tt_q != MB'(1) && i_q < mm_q) begin
          mul_x_d   = tt_q;
          mul_y_d   = tt_q;
          mul_ret_d = mau_pkg::ST_TS_SQR;
          state_d   = mau_pkg::ST_MUL_GO;
        end else if (tt_q != MB'(1) || i_q == mm_q) begin
          // squarings ran out: a has no root, or the modulus is composite
          rv_d    = 1'b1;
          val_d   = '0;
          eq_d    = 1'b0;
          nr_d    = 1'b1;
          last_d  = 1'b1;
          state_d = mau_pkg::ST_IDLE;
        end else begin
          tb_d    = c_q;
          j_d     = '0;
          state_d = mau_pkg::ST_TS_B;
        end
      end
      mau_pkg::ST_TS_SQR: begin
        tt_d    = mul_res_q;
        i_d     = i_q + 1'b1;
        state_d = mau_pkg::ST_TS_SQ;
      end
      mau_pkg::ST_TS_B: begin
        mul_x_d = tb_q;
        mul_y_d = tb_q;
        state_d = mau_pkg::ST_MUL_GO;
        if (jsum < (SW + 1)'(mm_q)) begin
          mul_ret_d = mau_pkg::ST_TS_BR;
        end else begin
          mm_d      = i_q;
          mul_ret_d = mau_pkg::ST_TS_C2;
        end
      end
      mau_pkg::ST_TS_BR: begin
        tb_d    = mul_res_q;
        j_d     = j_q + 1'b1;
        state_d = mau_pkg::ST_TS_B;
      end
      mau_pkg::ST_TS_C2: begin
        c_d       = mul_res_q;
        mul_x_d   = t_q;
        mul_y_d   = mul_res_q;
        mul_ret_d = mau_pkg::ST_TS_T2;
        state_d   = mau_pkg::ST_MUL_GO;
      end
      mau_pkg::ST_TS_T2: begin
        t_d       = mul_res_q;
        mul_x_d   = r_q;
        mul_y_d   = tb_q;
        mul_ret_d = mau_pkg::ST_TS_R2;
        state_d   = mau_pkg::ST_MUL_GO;
      end
      mau_pkg::ST_TS_R2: begin
        r_d     = mul_res_q;
        state_d = mau_pkg::ST_TS_LOOP;
      end

      // second root is the negation of the first
      mau_pkg::ST_ROOT2: begin
        rv_d    = 1'b1;
        val_d   = neg_r;
        eq_d    = 1'b0;
        nr_d    = 1'b0;
        last_d  = 1'b1;
        state_d = mau_pkg::ST_IDLE;
      end

      default: begin
        state_d = mau_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mau_pkg::ST_IDLE;
      rv_q      <= 1'b0;
      modulus_q <= MB'(mau_pkg::MOD_RESET);
    end else begin
      state_q <= state_d;
      rv_q    <= rv_d;
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_ret_q <= mul_ret_d;
    pow_ret_q <= pow_ret_d;
    red_ret_q <= red_ret_d;
    op_q      <= op_d;
    m_q       <= m_d;
    e_q       <= e_d;
    rhs_q     <= rhs_d;
    red_in_q  <= red_in_d;
    red_res_q <= red_res_d;
    a_q       <= a_d;
    b_q       <= b_d;
    mul_x_q   <= mul_x_d;
    mul_y_q   <= mul_y_d;
    mul_res_q <= mul_res_d;
    pw_base_q <= pw_base_d;
    pw_exp_q  <= pw_exp_d;
    pw_res_q  <= pw_res_d;
    eu_a_q    <= eu_a_d;
    eu_b_q    <= eu_b_d;
    eu_x_q    <= eu_x_d;
    eu_u_q    <= eu_u_d;
    sq_q      <= sq_d;
    s_q       <= s_d;
    i_q       <= i_d;
    j_q       <= j_d;
    mm_q      <= mm_d;
    lim_q     <= lim_d;
    z0_q      <= z0_d;
    z_q       <= z_d;
    c_q       <= c_d;
    t_q       <= t_d;
    r_q       <= r_d;
    tt_q      <= tt_d;
    tb_q      <= tb_d;
    val_q     <= val_d;
    eq_q      <= eq_d;
    nr_q      <= nr_d;
    last_q    <= last_d;
  end

  assign busy_o         = (state_q != mau_pkg::ST_IDLE);
  assign result_valid_o = rv_q;
  assign value_o        = val_q;
  assign is_equal_o     = eq_q;
  assign no_root_o      = nr_q;
  assign last_o         = last_q;

endmodule

/* hw/rtl/mau_div.sv */
// ----------------------------------------------------------------------------
// mau_div
// restoring divider, one quotient bit per cycle, shared by all reductions
// ----------------------------------------------------------------------------
module mau_div #(
  parameter int MOD_BITS = mau_pkg::MOD_BITS_DEF,
  localparam int DW = (2 * MOD_BITS > mau_pkg::OPND_BITS) ? 2 * MOD_BITS : mau_pkg::OPND_BITS,
  localparam int NW = $clog2(DW + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DW-1:0]       dividend_i,
  input  logic [MOD_BITS-1:0] divisor_i,
  input  logic [NW-1:0]       nbits_i,
  output logic                done_o,
  output logic [DW-1:0]       quot_o,
  output logic [MOD_BITS-1:0] rem_o
);

  logic                busy_q;
  logic [NW-1:0]       cnt_q;
  logic [DW-1:0]       dvd_q;
  logic [DW-1:0]       quot_q;
  logic [MOD_BITS-1:0] rem_q;
  logic [MOD_BITS-1:0] dsr_q;
  logic [MOD_BITS:0]   trial;
  logic [MOD_BITS:0]   diff;
  logic                ge;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= nbits_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // align the used bits to the top of the shift register
      dvd_q  <= dividend_i << (NW'(DW) - nbits_i);
      quot_q <= '0;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q && cnt_q != '0) begin
      rem_q  <= ge ? diff[MOD_BITS-1:0] : trial[MOD_BITS-1:0];
      quot_q <= {quot_q[DW-2:0], ge};
      dvd_q  <= {dvd_q[DW-2:0], 1'b0};
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
